// ===== hdl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// shared constants, types and state codes of the silhouette score core
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned MaxClusters = 16;
  localparam int unsigned PtAw        = $clog2(MaxPoints);
  localparam int unsigned CntW        = PtAw + 1;
  localparam int unsigned LblW        = 4;
  localparam int unsigned KW          = 5;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned DistW       = 17;
  localparam int unsigned SumW        = 32;
  localparam int unsigned DivW        = 32;
  localparam int unsigned RamW        = 2 * CoordW + LblW;

  typedef struct packed {
    logic [CntW-1:0] n;
    logic [KW-1:0]   k;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [PtAw-1:0]   addr;
    logic [RamW-1:0]   data;
  } wr_t;

  typedef enum logic [19:0] {
    S_IDLE  = 20'd1 << 0,
    S_RDI   = 20'd1 << 1,
    S_GETI  = 20'd1 << 2,
    S_RDJ   = 20'd1 << 3,
    S_GETJ  = 20'd1 << 4,
    S_MUL   = 20'd1 << 5,
    S_ADD   = 20'd1 << 6,
    S_SQRT  = 20'd1 << 7,
    S_NEXTJ = 20'd1 << 8,
    S_OWN   = 20'd1 << 9,
    S_DIVA  = 20'd1 << 10,
    S_CSCAN = 20'd1 << 11,
    S_DIVB  = 20'd1 << 12,
    S_SCORE = 20'd1 << 13,
    S_DIVS  = 20'd1 << 14,
    S_ACC   = 20'd1 << 15,
    S_NEXTI = 20'd1 << 16,
    S_MEAN  = 20'd1 << 17,
    S_DIVM  = 20'd1 << 18,
    S_OUT   = 20'd1 << 19
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/ssc_ram.sv =====
// ----------------------------------------------------------------------------
// ssc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/ssc_div.sv =====
// ----------------------------------------------------------------------------
// ssc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [ssc_pkg::DivW-1:0] dividend_i,
  input  wire logic [ssc_pkg::DivW-1:0] divisor_i,
  output logic                          done_o,
  output logic      [ssc_pkg::DivW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(ssc_pkg::DivW);

  logic [ssc_pkg::DivW-1:0] n_q, d_q;
  logic [ssc_pkg::DivW:0]   r_q, r_sh;
  logic [CW-1:0]            cnt_q;
  logic                     busy_q, done_q, ge;

  assign r_sh   = {r_q[ssc_pkg::DivW-1:0], n_q[ssc_pkg::DivW-1]};
  assign ge     = r_sh >= {1'b0, d_q};
  assign done_o = done_q;
  assign quot_o = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ssc_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= dividend_i;
      d_q <= divisor_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
      n_q <= {n_q[ssc_pkg::DivW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ssc_front.sv =====
// ----------------------------------------------------------------------------
// ssc_front
// loader: stores points, holds the config register, queues one job
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [ssc_pkg::CoordW-1:0] coord_x_i,
  input  wire logic signed [ssc_pkg::CoordW-1:0] coord_y_i,
  input  wire logic [ssc_pkg::LblW-1:0]      cluster_label_i,
  input  wire logic                          last_i,
  input  wire logic                          cfg_valid,
  input  wire logic [ssc_pkg::KW-1:0]        cfg_data_i,
  input  wire logic                          back_busy_i,
  input  wire logic                          job_pop_i,
  output logic                               job_valid_o,
  output ssc_pkg::job_t                      job_o,
  output ssc_pkg::wr_t                       wr_o
);

  logic [ssc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [ssc_pkg::KW-1:0]   cfg_q, k_eff;
  logic                     job_valid_q, acc, store;
  ssc_pkg::job_t            job_q;

  assign full        = job_valid_q | back_busy_i;
  assign acc         = push & ~full;
  assign store       = cnt_q < ssc_pkg::CntW'(ssc_pkg::MaxPoints);
  assign cnt_d       = store ? cnt_q + 1'b1 : cnt_q;
  assign k_eff       = (cfg_q > ssc_pkg::KW'(ssc_pkg::MaxClusters)) ?
                       ssc_pkg::KW'(ssc_pkg::MaxClusters) : cfg_q;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  assign wr_o.we   = acc & store;
  assign wr_o.addr = cnt_q[ssc_pkg::PtAw-1:0];
  assign wr_o.data = {coord_x_i, coord_y_i, cluster_label_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cfg_q       <= ssc_pkg::KW'(2);
      job_valid_q <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_q <= cfg_data_i;
      end
      if (job_pop_i) begin
        job_valid_q <= 1'b0;
      end
      if (acc) begin
        if (last_i) begin
          cnt_q       <= '0;
          job_valid_q <= 1'b1;
        end else begin
          cnt_q <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && last_i) begin
      job_q.n <= cnt_d;
      job_q.k <= k_eff;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ssc_back.sv =====
// ----------------------------------------------------------------------------
// ssc_back
// compute engine: pairwise distances, cluster means, scores and the average
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  input  ssc_pkg::job_t                      job_i,
  output logic                               job_pop_o,
  output logic                               busy_o,
  output logic [ssc_pkg::PtAw-1:0]           raddr_o,
  input  wire logic [ssc_pkg::RamW-1:0]      rdata_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [15:0]                 silhouette_o,
  output logic [ssc_pkg::CntW-1:0]           points_used_o,
  output logic                               label_error_o
);

  localparam int unsigned CW = ssc_pkg::CoordW;
  localparam int unsigned DW = ssc_pkg::DistW;
  localparam int unsigned NW = ssc_pkg::CntW;

  ssc_pkg::state_e state_q, state_d;

  logic [ssc_pkg::PtAw-1:0]  i_q, j_q;
  logic [NW-1:0]             n_q, valid_q;
  logic [ssc_pkg::KW-1:0]    k_q, c_q;
  logic signed [CW-1:0]      xi_q, yi_q, xj, yj;
  logic [ssc_pkg::LblW-1:0]  own_q, lj_q, lj;
  logic signed [CW:0]        dx_q, dy_q;
  logic signed [2*CW+1:0]    px, py;
  logic [2*CW-1:0]           sqx_q, sqy_q;
  logic [35:0]               rad_q;
  logic [19:0]               rem_q, rem_n;
  logic [21:0]               rem_sh, trial;
  logic [17:0]               root_q, root_n;
  logic [4:0]                it_q;
  logic                      sq_ge;
  logic [ssc_pkg::SumW-1:0]  sums_q [ssc_pkg::MaxClusters];
  logic [NW-1:0]             cnts_q [ssc_pkg::MaxClusters];
  logic [DW-1:0]             a_q, b_q, m, mag;
  logic                      have_b_q, neg_q, err_q;
  logic signed [15:0]        score_q;
  logic [31:0]               total_q, tot_mag;
  logic                      out_valid_q, out_err_q;
  logic signed [15:0]        out_sil_q;
  logic [NW-1:0]             out_n_q;
  logic                      div_start, div_done;
  logic [ssc_pkg::DivW-1:0]  div_n, div_d, div_q;
  logic                      lbl_bad, i_last, j_last;
  logic [3:0]                c_idx;

  assign xj  = rdata_i[ssc_pkg::RamW-1 -: CW];
  assign yj  = rdata_i[ssc_pkg::LblW +: CW];
  assign lj  = rdata_i[ssc_pkg::LblW-1:0];
  assign lbl_bad = {1'b0, lj} >= k_q;
  assign i_last  = (NW'(i_q) + 1'b1) == n_q;
  assign j_last  = (NW'(j_q) + 1'b1) == n_q;
  assign c_idx   = c_q[3:0];

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  assign rem_sh = {rem_q, rad_q[35:34]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign rem_n  = sq_ge ? 20'(rem_sh - trial) : rem_sh[19:0];
  assign root_n = {root_q[16:0], sq_ge};

  assign m       = (a_q > b_q) ? a_q : b_q;
  assign mag     = (b_q >= a_q) ? b_q - a_q : a_q - b_q;
  assign tot_mag = total_q[31] ? 32'(-total_q) : total_q;

  assign job_pop_o     = (state_q == ssc_pkg::S_IDLE) & job_valid_i;
  assign busy_o        = state_q != ssc_pkg::S_IDLE;
  assign raddr_o       = (state_q == ssc_pkg::S_RDI) ? i_q : j_q;
  assign empty         = ~out_valid_q;
  assign silhouette_o  = out_sil_q;
  assign points_used_o = out_n_q;
  assign label_error_o = out_err_q;

  ssc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_q)
      ssc_pkg::S_OWN: begin
        div_start = cnts_q[own_q] != '0;
        div_n     = sums_q[own_q];
        div_d     = 32'(cnts_q[own_q]);
      end
      ssc_pkg::S_CSCAN: begin
        div_start = (c_q < k_q) && (c_idx != own_q) && (cnts_q[c_idx] != '0);
        div_n     = sums_q[c_idx];
        div_d     = 32'(cnts_q[c_idx]);
      end
      ssc_pkg::S_SCORE: begin
        div_start = have_b_q && (m != '0);
        div_n     = {mag, 15'd0};
        div_d     = 32'(m);
      end
      ssc_pkg::S_MEAN: begin
        div_start = valid_q != '0;
        div_n     = tot_mag;
        div_d     = 32'(valid_q);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssc_pkg::S_IDLE:  if (job_valid_i) state_d = ssc_pkg::S_RDI;
      ssc_pkg::S_RDI:   state_d = ssc_pkg::S_GETI;
      ssc_pkg::S_GETI:  state_d = lbl_bad ? ssc_pkg::S_NEXTI : ssc_pkg::S_RDJ;
      ssc_pkg::S_RDJ:   state_d = ssc_pkg::S_GETJ;
      ssc_pkg::S_GETJ:  state_d = (lbl_bad || j_q == i_q) ? ssc_pkg::S_NEXTJ : ssc_pkg::S_MUL;
      ssc_pkg::S_MUL:   state_d = ssc_pkg::S_ADD;
      ssc_pkg::S_ADD:   state_d = ssc_pkg::S_SQRT;
      ssc_pkg::S_SQRT:  if (it_q == 5'd17) state_d = ssc_pkg::S_NEXTJ;
      ssc_pkg::S_NEXTJ: state_d = j_last ? ssc_pkg::S_OWN : ssc_pkg::S_RDJ;
      ssc_pkg::S_OWN:   state_d = div_start ? ssc_pkg::S_DIVA : ssc_pkg::S_ACC;
      ssc_pkg::S_DIVA:  if (div_done) state_d = ssc_pkg::S_CSCAN;
      ssc_pkg::S_CSCAN: begin
        if (c_q >= k_q) begin
          state_d = ssc_pkg::S_SCORE;
        end else if (div_start) begin
          state_d = ssc_pkg::S_DIVB;
        end
      end
      ssc_pkg::S_DIVB:  if (div_done) state_d = ssc_pkg::S_CSCAN;
      ssc_pkg::S_SCORE: state_d = div_start ? ssc_pkg::S_DIVS : ssc_pkg::S_ACC;
      ssc_pkg::S_DIVS:  if (div_done) state_d = ssc_pkg::S_ACC;
      ssc_pkg::S_ACC:   state_d = ssc_pkg::S_NEXTI;
      ssc_pkg::S_NEXTI: state_d = i_last ? ssc_pkg::S_MEAN : ssc_pkg::S_RDI;
      ssc_pkg::S_MEAN:  state_d = div_start ? ssc_pkg::S_DIVM : ssc_pkg::S_OUT;
      ssc_pkg::S_DIVM:  if (div_done) state_d = ssc_pkg::S_OUT;
      ssc_pkg::S_OUT:   if (!out_valid_q) state_d = ssc_pkg::S_IDLE;
      default:          state_d = ssc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ssc_pkg::S_OUT && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ssc_pkg::S_IDLE: begin
        n_q     <= job_i.n;
        k_q     <= job_i.k;
        i_q     <= '0;
        total_q <= '0;
        valid_q <= '0;
        err_q   <= 1'b0;
      end
      ssc_pkg::S_GETI: begin
        if (lbl_bad) begin
          err_q <= 1'b1;
        end
        xi_q  <= xj;
        yi_q  <= yj;
        own_q <= lj;
        j_q   <= '0;
        c_q   <= '0;
        have_b_q <= 1'b0;
        score_q  <= '0;
        for (int c = 0; c < ssc_pkg::MaxClusters; c++) begin
          sums_q[c] <= '0;
          cnts_q[c] <= '0;
        end
      end
      ssc_pkg::S_GETJ: begin
        dx_q <= (CW+1)'(xi_q) - (CW+1)'(xj);
        dy_q <= (CW+1)'(yi_q) - (CW+1)'(yj);
        lj_q <= lj;
      end
      ssc_pkg::S_MUL: begin
        sqx_q <= px[2*CW-1:0];
        sqy_q <= py[2*CW-1:0];
      end
      ssc_pkg::S_ADD: begin
        rad_q  <= 36'(sqx_q) + 36'(sqy_q);
        rem_q  <= '0;
        root_q <= '0;
        it_q   <= '0;
      end
      ssc_pkg::S_SQRT: begin
        rad_q  <= {rad_q[33:0], 2'b00};
        rem_q  <= rem_n;
        root_q <= root_n;
        it_q   <= it_q + 1'b1;
        if (it_q == 5'd17) begin
          sums_q[lj_q] <= sums_q[lj_q] + 32'(root_n);
          cnts_q[lj_q] <= cnts_q[lj_q] + 1'b1;
        end
      end
      ssc_pkg::S_NEXTJ: j_q <= j_q + 1'b1;
      ssc_pkg::S_DIVA:  if (div_done) a_q <= div_q[DW-1:0];
      ssc_pkg::S_CSCAN: begin
        if (c_q < k_q && !div_start) begin
          c_q <= c_q + 1'b1;
        end
      end
      ssc_pkg::S_DIVB: begin
        if (div_done) begin
          if (!have_b_q || div_q[DW-1:0] < b_q) begin
            b_q <= div_q[DW-1:0];
          end
          have_b_q <= 1'b1;
          c_q      <= c_q + 1'b1;
        end
      end
      ssc_pkg::S_SCORE: neg_q <= b_q < a_q;
      ssc_pkg::S_DIVS: begin
        if (div_done) begin
          if (!neg_q) begin
            score_q <= (div_q > 32'd32767) ? 16'sd32767 : $signed(div_q[15:0]);
          end else begin
            score_q <= (div_q > 32'd32768) ? -16'sd32768 : $signed(16'(-div_q[15:0]));
          end
        end
      end
      ssc_pkg::S_ACC: begin
        total_q <= total_q + 32'(score_q);
        valid_q <= valid_q + 1'b1;
      end
      ssc_pkg::S_NEXTI: i_q <= i_q + 1'b1;
      ssc_pkg::S_MEAN:  neg_q <= total_q[31];
      ssc_pkg::S_DIVM: begin
        if (div_done) begin
          total_q <= neg_q ? 32'(-div_q) : div_q;
        end
      end
      ssc_pkg::S_OUT: begin
        if (!out_valid_q) begin
          out_sil_q <= (valid_q == '0) ? 16'sd0 : $signed(total_q[15:0]);
          out_n_q   <= n_q;
          out_err_q <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/silhouette_score_core.sv =====
// ----------------------------------------------------------------------------
// silhouette_score_core
// mean euclidean silhouette coefficient of a labeled 2-d point set
// ----------------------------------------------------------------------------
//  channel   | handshake              | words
//  input     | push / full            | coord_x_i, coord_y_i, cluster_label_i, last_i
//  result    | pop / empty            | silhouette_o, points_used_o, label_error_o
//  config    | cfg_valid / cfg_ready  | cfg_data_i (num_clusters)
//
//  loading takes one word per cycle while full is low; full rises after
//  the word with last set and stays high until the set is scored and its
//  result is registered. scoring is quadratic in the set size n: each pair
//  goes through the 18-step square root unit, plus divides per cluster mean.
//  a waiting result does not block loading of the next set.
//  reset is asynchronous active low; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module silhouette_score_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [15:0]            coord_x_i,
  input  wire logic signed [15:0]            coord_y_i,
  input  wire logic [3:0]                    cluster_label_i,
  input  wire logic                          last_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [15:0]                 silhouette_o,
  output logic [10:0]                        points_used_o,
  output logic                               label_error_o,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [4:0]                    cfg_data_i
);

  ssc_pkg::job_t              job;
  ssc_pkg::wr_t               wr;
  logic                       job_valid, job_pop, back_busy;
  logic [ssc_pkg::PtAw-1:0]   raddr;
  logic [ssc_pkg::RamW-1:0]   rdata;

  assign cfg_ready = 1'b1;

  ssc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .cluster_label_i (cluster_label_i),
    .last_i          (last_i),
    .cfg_valid       (cfg_valid),
    .cfg_data_i      (cfg_data_i),
    .back_busy_i     (back_busy),
    .job_pop_i       (job_pop),
    .job_valid_o     (job_valid),
    .job_o           (job),
    .wr_o            (wr)
  );

  ssc_ram #(
    .Width (ssc_pkg::RamW),
    .Depth (ssc_pkg::MaxPoints)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ssc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_pop_o     (job_pop),
    .busy_o        (back_busy),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .empty         (empty),
    .pop           (pop),
    .silhouette_o  (silhouette_o),
    .points_used_o (points_used_o),
    .label_error_o (label_error_o)
  );

endmodule

`default_nettype wire

// ===== hdl/ssc_core_chk.sv =====
// ----------------------------------------------------------------------------
// ssc_core_chk
// port level checks of the silhouette score core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_core_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        last_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] silhouette_o,
  input wire logic [10:0] points_used_o
);

  // a waiting result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(silhouette_o))
    else $error("result changed while stalled");

  // the input is blocked once a set is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && last_i |=> full)
    else $error("input open right after last word");

  // every result covers at least one and at most the store size of points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (points_used_o != 11'd0) && (points_used_o <= 11'd1024))
    else $error("points used out of range");

endmodule

bind silhouette_score_core ssc_core_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .last_i        (last_i),
  .empty         (empty),
  .pop           (pop),
  .silhouette_o  (silhouette_o),
  .points_used_o (points_used_o)
);

`default_nettype wire
